// ===== sv/acet_pkg.sv =====
// Shared types and constants of the AABB contact event tracker.
package acet_pkg;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_BEGIN = 2'd1,
      EV_STAY  = 2'd2,
      EV_END   = 2'd3
   } event_type;

   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } clr_state_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_BITS   = 1;
   localparam int unsigned QCNT_BITS   = 2;

endpackage

// ===== sv/aabb_contact_event_tracker_top.sv =====
// Top level of the AABB contact event tracker.
// Each item is a collider pair; the block reports whether the two centered boxes overlap
// and a begin, stay, end or no event from one contact bit kept per ordered ID pair.
// After reset the contact-bit memory is cleared one entry per cycle over all
// MAX_COLLIDERS*MAX_COLLIDERS entries, with req_ready low. After that the block takes one
// item per cycle while rsp_ready does not hold results back, and gives one result per item
// through the classify register, queue, contact-bit read and result register in turn;
// the rate is set by the single read and single write port of the contact-bit memory,
// with the last write forwarded so that back-to-back items on one pair see fresh state.
module aabb_contact_event_tracker_top import acet_pkg::*; #(
   parameter int unsigned MAX_COLLIDERS = 64,
   parameter int unsigned COORD_BITS    = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [$clog2(MAX_COLLIDERS)-1:0]  req_left_id,
   input  logic [$clog2(MAX_COLLIDERS)-1:0]  req_right_id,
   input  logic signed [COORD_BITS-1:0]      req_left_x,
   input  logic signed [COORD_BITS-1:0]      req_left_y,
   input  logic signed [COORD_BITS-1:0]      req_left_w,
   input  logic signed [COORD_BITS-1:0]      req_left_h,
   input  logic signed [COORD_BITS-1:0]      req_right_x,
   input  logic signed [COORD_BITS-1:0]      req_right_y,
   input  logic signed [COORD_BITS-1:0]      req_right_w,
   input  logic signed [COORD_BITS-1:0]      req_right_h,
   input  logic                              req_either_dead,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_contact_event,
   output logic                              rsp_boxes_overlap
);

   localparam int unsigned ADDR_BITS = $clog2(MAX_COLLIDERS * MAX_COLLIDERS);

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic                 pair_ok;
      logic                 dead;
      logic                 hit;
   } pair_type;

   logic     clear_busy;
   logic     push_valid, push_ready;
   pair_type push_item;
   logic     pop_valid, pop_ready;
   pair_type pop_item;

   acet_front #(
      .MAX_COLLIDERS (MAX_COLLIDERS),
      .COORD_BITS    (COORD_BITS),
      .pair_type     (pair_type)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .enable          (!clear_busy),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_id     (req_left_id),
      .req_right_id    (req_right_id),
      .req_left_x      (req_left_x),
      .req_left_y      (req_left_y),
      .req_left_w      (req_left_w),
      .req_left_h      (req_left_h),
      .req_right_x     (req_right_x),
      .req_right_y     (req_right_y),
      .req_right_w     (req_right_w),
      .req_right_h     (req_right_h),
      .req_either_dead (req_either_dead),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   acet_queue #(
      .pair_type (pair_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   acet_back #(
      .MAX_COLLIDERS (MAX_COLLIDERS),
      .pair_type     (pair_type)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_item          (pop_item),
      .clear_busy        (clear_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_contact_event (rsp_contact_event),
      .rsp_boxes_overlap (rsp_boxes_overlap)
   );

`ifndef ASSERT_OFF
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_begin_overlaps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_contact_event == EV_BEGIN)) |-> rsp_boxes_overlap)
      else $error("begin event without overlap");

   a_stay_overlaps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_contact_event == EV_STAY)) |-> rsp_boxes_overlap)
      else $error("stay event without overlap");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_valid)
      else $error("result during clearing pass");
`endif

endmodule

// ===== sv/acet_front.sv =====
// Front stage: accepts pairs, computes box differences, classifies overlap and pair address.
module acet_front import acet_pkg::*; #(
   parameter int unsigned MAX_COLLIDERS = 64,
   parameter int unsigned COORD_BITS    = 16,
   parameter type         pair_type     = logic
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [$clog2(MAX_COLLIDERS)-1:0]       req_left_id,
   input  logic [$clog2(MAX_COLLIDERS)-1:0]       req_right_id,
   input  logic signed [COORD_BITS-1:0]           req_left_x,
   input  logic signed [COORD_BITS-1:0]           req_left_y,
   input  logic signed [COORD_BITS-1:0]           req_left_w,
   input  logic signed [COORD_BITS-1:0]           req_left_h,
   input  logic signed [COORD_BITS-1:0]           req_right_x,
   input  logic signed [COORD_BITS-1:0]           req_right_y,
   input  logic signed [COORD_BITS-1:0]           req_right_w,
   input  logic signed [COORD_BITS-1:0]           req_right_h,
   input  logic                                   req_either_dead,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output pair_type                               push_item
);

   localparam int unsigned ID_BITS   = $clog2(MAX_COLLIDERS);
   localparam int unsigned DEPTH     = MAX_COLLIDERS * MAX_COLLIDERS;
   localparam int unsigned ADDR_BITS = $clog2(DEPTH);
   localparam int unsigned DW        = COORD_BITS + 1;

   logic                   valid_ff, valid_in;
   logic signed [DW-1:0]   dx_ff, dy_ff, sx_ff, sy_ff;
   logic                   zero_ff, ok_ff, dead_ff;
   logic [ADDR_BITS-1:0]   addr_ff;

   logic                   req_fire;
   logic                   ok_in;
   logic [DW-1:0]          mdx, mdy, msx, msy;
   logic                   apart_x, apart_y;

   assign req_ready = enable && (!valid_ff || push_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   assign ok_in = (req_left_id != req_right_id)
               && ({1'b0, req_left_id} < (ID_BITS + 1)'(MAX_COLLIDERS))
               && ({1'b0, req_right_id} < (ID_BITS + 1)'(MAX_COLLIDERS));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dx_ff   <= DW'(req_left_x) - DW'(req_right_x);
         dy_ff   <= DW'(req_left_y) - DW'(req_right_y);
         sx_ff   <= DW'(req_left_w) + DW'(req_right_w);
         sy_ff   <= DW'(req_left_h) + DW'(req_right_h);
         zero_ff <= ((req_left_w == '0) && (req_left_h == '0))
                 || ((req_right_w == '0) && (req_right_h == '0));
         ok_ff   <= ok_in;
         dead_ff <= req_either_dead;
         addr_ff <= ADDR_BITS'(req_left_id) * ADDR_BITS'(MAX_COLLIDERS)
                  + ADDR_BITS'(req_right_id);
      end
   end

   // magnitudes as unsigned, the most negative value maps to 2**COORD_BITS
   assign mdx = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
   assign mdy = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
   assign msx = sx_ff[DW-1] ? DW'(-sx_ff) : DW'(sx_ff);
   assign msy = sy_ff[DW-1] ? DW'(-sy_ff) : DW'(sy_ff);

   assign apart_x = {mdx, 1'b0} > {1'b0, msx};
   assign apart_y = {mdy, 1'b0} > {1'b0, msy};

   assign push_valid        = valid_ff;
   assign push_item.addr    = addr_ff;
   assign push_item.pair_ok = ok_ff;
   assign push_item.dead    = dead_ff;
   assign push_item.hit     = !zero_ff && !apart_x && !apart_y;

endmodule

// ===== sv/acet_queue.sv =====
// Two-entry queue between the classify front and the contact-bit back.
module acet_queue import acet_pkg::*; #(
   parameter type pair_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  pair_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output pair_type pop_item
);

   pair_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push_fire, pop_fire;

   assign push_ready = count_ff < QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/acet_back.sv =====
// Back stage: contact-bit memory with clearing pass, read-modify-write and result register.
module acet_back import acet_pkg::*; #(
   parameter int unsigned MAX_COLLIDERS = 64,
   parameter type         pair_type     = logic
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  pair_type   pop_item,
   output logic       clear_busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_contact_event,
   output logic       rsp_boxes_overlap
);

   localparam int unsigned DEPTH     = MAX_COLLIDERS * MAX_COLLIDERS;
   localparam int unsigned ADDR_BITS = $clog2(DEPTH);

   logic                  mem [DEPTH];

   clr_state_type         state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_cnt_ff, clr_cnt_in;

   logic                  b_valid_ff, b_valid_in;
   pair_type              b_item_ff;
   logic                  rdata_ff;
   logic                  fwd_valid_ff;
   logic [ADDR_BITS-1:0]  fwd_addr_ff;
   logic                  fwd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   event_type             rsp_event_ff;
   logic                  rsp_overlap_ff;

   logic                  b_fire, b_load, pop_fire;
   logic                  prev;
   event_type             ev;
   logic                  do_write;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic                  mem_wdata;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_BITS'(DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_CLEAR: clear_busy = 1'b1;
         ST_RUN:   clear_busy = 1'b0;
         default:  clear_busy = 1'b1;
      endcase
   end

   assign clr_cnt_in = clear_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   assign b_fire    = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign b_load    = !b_valid_ff || b_fire;
   assign pop_ready = b_load && !clear_busy;
   assign pop_fire  = pop_valid && pop_ready;

   assign b_valid_in   = pop_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
   assign rsp_valid_in = b_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // last write may land at the edge this item was read
   assign prev = (fwd_valid_ff && (fwd_addr_ff == b_item_ff.addr)) ? fwd_data_ff : rdata_ff;

   always_comb begin
      ev       = EV_NONE;
      do_write = 1'b0;
      if (b_item_ff.pair_ok) begin
         if (b_item_ff.hit) begin
            if (prev) begin
               ev = b_item_ff.dead ? EV_END : EV_STAY;
            end else if (!b_item_ff.dead) begin
               ev       = EV_BEGIN;
               do_write = 1'b1;
            end
         end else if (prev) begin
            ev       = EV_END;
            do_write = 1'b1;
         end
      end
   end

   assign mem_we    = clear_busy || (b_fire && do_write);
   assign mem_waddr = clear_busy ? clr_cnt_ff : b_item_ff.addr;
   assign mem_wdata = clear_busy ? 1'b0 : b_item_ff.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         b_valid_ff <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_fire && do_write) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (pop_fire) begin
         rdata_ff  <= mem[pop_item.addr];
         b_item_ff <= pop_item;
      end
      if (b_fire && do_write) begin
         fwd_addr_ff <= b_item_ff.addr;
         fwd_data_ff <= b_item_ff.hit;
      end
      if (b_fire) begin
         rsp_event_ff   <= ev;
         rsp_overlap_ff <= b_item_ff.hit;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_contact_event = rsp_event_ff;
   assign rsp_boxes_overlap = rsp_overlap_ff;

endmodule

// ===== tb/sv/tb_aabb_contact_event_tracker_top.sv =====
// AABB contact event tracker bench: directed and random pairs, predictor or typed-in checks.
module tb_aabb_contact_event_tracker_top;
   import acet_pkg::*;

   localparam int NUM_IDS  = 64;
   localparam int ID_BITS  = 6;
   localparam int CB       = 16;
   localparam int RUN_LEN  = 370;

   typedef struct {
      logic [ID_BITS-1:0]   lid;
      logic [ID_BITS-1:0]   rid;
      logic signed [CB-1:0] lx;
      logic signed [CB-1:0] ly;
      logic signed [CB-1:0] lw;
      logic signed [CB-1:0] lh;
      logic signed [CB-1:0] rx;
      logic signed [CB-1:0] ry;
      logic signed [CB-1:0] rw;
      logic signed [CB-1:0] rh;
      logic                 dead;
      bit                   fixed;
      event_type            ev;
      logic                 ovl;
   } pair_row_type;

   typedef struct {
      event_type ev;
      logic      ovl;
   } contact_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ID_BITS-1:0]   req_left_id = '0;
   logic [ID_BITS-1:0]   req_right_id = '0;
   logic signed [CB-1:0] req_left_x = '0;
   logic signed [CB-1:0] req_left_y = '0;
   logic signed [CB-1:0] req_left_w = '0;
   logic signed [CB-1:0] req_left_h = '0;
   logic signed [CB-1:0] req_right_x = '0;
   logic signed [CB-1:0] req_right_y = '0;
   logic signed [CB-1:0] req_right_w = '0;
   logic signed [CB-1:0] req_right_h = '0;
   logic                 req_either_dead = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_contact_event;
   logic                 rsp_boxes_overlap;

   // typed-in expectation travelling with the current item
   bit                   row_fixed = 1'b0;
   event_type            row_ev = EV_NONE;
   logic                 row_ovl = 1'b0;

   int unsigned          gap_pct = 17;
   int unsigned          rsp_stall_pct = 75;

   bit                   pair_contact [NUM_IDS][NUM_IDS];
   contact_result_type   pending_events [$];
   pair_row_type         directed_rows [$];
   int                   mismatch_count = 0;
   int                   items_taken = 0;
   int                   results_seen = 0;
   int                   event_tally [4];

   aabb_contact_event_tracker_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_id       (req_left_id),
      .req_right_id      (req_right_id),
      .req_left_x        (req_left_x),
      .req_left_y        (req_left_y),
      .req_left_w        (req_left_w),
      .req_left_h        (req_left_h),
      .req_right_x       (req_right_x),
      .req_right_y       (req_right_y),
      .req_right_w       (req_right_w),
      .req_right_h       (req_right_h),
      .req_either_dead   (req_either_dead),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_contact_event (rsp_contact_event),
      .rsp_boxes_overlap (rsp_boxes_overlap)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1_600_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit axis_apart(longint pa, longint sa, longint pb, longint sb);
      longint d;
      longint s;
      d = pa - pb;
      s = sa + sb;
      if (d < 0) d = -d;
      if (s < 0) s = -s;
      return 2 * d > s;
   endfunction

   function automatic contact_result_type predict_contact(pair_row_type r);
      contact_result_type res;
      bit hit;
      bit was;
      hit = !((r.lw == 0 && r.lh == 0) || (r.rw == 0 && r.rh == 0)) &&
            !axis_apart(r.lx, r.lw, r.rx, r.rw) && !axis_apart(r.ly, r.lh, r.ry, r.rh);
      res.ev  = EV_NONE;
      res.ovl = hit;
      if (r.lid != r.rid) begin
         was = pair_contact[r.lid][r.rid];
         if (hit) begin
            if (was) begin
               res.ev = r.dead ? EV_END : EV_STAY;
            end else if (!r.dead) begin
               res.ev = EV_BEGIN;
               pair_contact[r.lid][r.rid] = 1'b1;
            end
         end else if (was) begin
            res.ev = EV_END;
            pair_contact[r.lid][r.rid] = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic pair_row_type pair_row(int lid, int rid, int lx, int ly, int lw, int lh,
                                             int rx, int ry, int rw, int rh, bit dead,
                                             bit fixed, event_type ev, bit ovl);
      pair_row_type r;
      r.lid = ID_BITS'(lid);  r.rid = ID_BITS'(rid);
      r.lx = CB'(lx);    r.ly = CB'(ly);    r.lw = CB'(lw);    r.lh = CB'(lh);
      r.rx = CB'(rx);    r.ry = CB'(ry);    r.rw = CB'(rw);    r.rh = CB'(rh);
      r.dead = dead;
      r.fixed = fixed;
      r.ev = ev;
      r.ovl = ovl;
      return r;
   endfunction

   // mostly plausible scenes on a few colliders; some noise and degenerate pairs
   function automatic pair_row_type random_pair();
      pair_row_type r;
      int unsigned pick;
      int bx;
      int by;
      pick = $urandom_range(99);
      bx = int'($urandom_range(60000)) - 30000;
      by = int'($urandom_range(60000)) - 30000;
      r = pair_row(($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                   ($urandom_range(3) == 0) ? $urandom : $urandom_range(7),
                   bx + int'($urandom_range(40)) - 20, by + int'($urandom_range(40)) - 20,
                   int'($urandom_range(48)) - 4, int'($urandom_range(48)) - 4,
                   bx + int'($urandom_range(40)) - 20, by + int'($urandom_range(40)) - 20,
                   int'($urandom_range(48)) - 4, int'($urandom_range(48)) - 4,
                   $urandom_range(7) == 0, 1'b0, EV_NONE, 1'b0);
      if (pick >= 90) begin
         case ($urandom_range(2))
            0: r.rid = r.lid;
            1: begin
               r.lw = '0;
               r.lh = '0;
            end
            default: begin
               r.rw = '0;
               r.rh = '0;
            end
         endcase
      end else if (pick >= 70) begin
         r = pair_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, bit'($urandom),
                      1'b0, EV_NONE, 1'b0);
      end
      return r;
   endfunction

   task automatic send_pair(pair_row_type r);
      req_left_id     <= r.lid;
      req_right_id    <= r.rid;
      req_left_x      <= r.lx;
      req_left_y      <= r.ly;
      req_left_w      <= r.lw;
      req_left_h      <= r.lh;
      req_right_x     <= r.rx;
      req_right_y     <= r.ry;
      req_right_w     <= r.rw;
      req_right_h     <= r.rh;
      req_either_dead <= r.dead;
      row_fixed       <= r.fixed;
      row_ev          <= r.ev;
      row_ovl         <= r.ovl;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // predict on accept, then check results in order
   always @(posedge clock) begin
      pair_row_type r;
      contact_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            r = pair_row(int'(req_left_id), int'(req_right_id), int'(req_left_x),
                         int'(req_left_y), int'(req_left_w), int'(req_left_h),
                         int'(req_right_x), int'(req_right_y), int'(req_right_w),
                         int'(req_right_h), req_either_dead, 1'b0, EV_NONE, 1'b0);
            want = predict_contact(r);
            if (row_fixed) begin
               want.ev  = row_ev;
               want.ovl = row_ovl;
            end
            pending_events.push_back(want);
            items_taken++;
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            results_seen++;
            if (pending_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result event=%0d overlap=%0b",
                           rsp_contact_event, rsp_boxes_overlap);
            end else begin
               want = pending_events.pop_front();
               event_tally[rsp_contact_event]++;
               if (rsp_contact_event !== want.ev || rsp_boxes_overlap !== want.ovl) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: result %0d event exp=%0d got=%0d overlap exp=%0b got=%0b",
                              results_seen, want.ev, rsp_contact_event, want.ovl,
                              rsp_boxes_overlap);
               end
            end
         end
      end
   end

   initial begin
      int ph;
      int n;
      directed_rows.push_back(pair_row(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 0, 1, EV_BEGIN, 1));
      directed_rows.push_back(pair_row(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 0, 1, EV_STAY, 1));
      directed_rows.push_back(pair_row(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 1, 1, EV_END, 1));
      directed_rows.push_back(pair_row(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 0, 1, EV_STAY, 1));
      directed_rows.push_back(pair_row(1, 2, 0, 0, 10, 10, 100, 0, 10, 10, 0, 1, EV_END, 0));
      directed_rows.push_back(pair_row(1, 2, 0, 0, 10, 10, 100, 0, 10, 10, 0, 1, EV_NONE, 0));
      directed_rows.push_back(pair_row(3, 4, 5, 5, 8, 8, 6, 6, 8, 8, 1, 1, EV_NONE, 1));
      directed_rows.push_back(pair_row(3, 4, 5, 5, 8, 8, 6, 6, 8, 8, 0, 1, EV_BEGIN, 1));
      directed_rows.push_back(pair_row(5, 5, 0, 0, 10, 10, 0, 0, 10, 10, 0, 1, EV_NONE, 1));
      directed_rows.push_back(pair_row(63, 63, -32768, -32768, 1, 1, 32767, 32767, 1, 1,
                                       0, 1, EV_NONE, 0));
      directed_rows.push_back(pair_row(2, 1, 0, 0, 10, 10, 0, 0, 10, 10, 0, 1, EV_BEGIN, 1));
      directed_rows.push_back(pair_row(10, 11, 0, 0, 0, 0, 0, 0, 10, 10, 0, 1, EV_NONE, 0));
      directed_rows.push_back(pair_row(12, 13, 0, 0, 10, 10, 0, 0, 0, 0, 0, 1, EV_NONE, 0));
      directed_rows.push_back(pair_row(12, 13, 0, 0, 10, 10, 0, 0, 0, 5, 0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(14, 15, -32768, 0, 32767, 4, 32767, 0, 32767, 4,
                                       0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(0, 63, 7, -9, -32768, -32768, 7, -9, -32768, -32768,
                                       0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(0, 63, 0, 0, 5, 5, 0, 0, -5, -5, 0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(20, 21, 0, 0, 10, 10, 10, 0, 10, 10, 0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(20, 21, 0, 0, 10, 10, 11, 0, 10, 10, 0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(20, 21, 0, 0, 10, 10, 0, -11, 10, 10, 0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(62, 63, 32767, 32767, 32767, 32767, 32767, 32767,
                                       32767, 32767, 0, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(62, 63, 32767, 32767, 32767, 32767, -32768, -32768,
                                       -32768, -32768, 1, 0, EV_NONE, 0));
      directed_rows.push_back(pair_row(62, 63, 1, 1, 4, 4, 2, 2, 4, 4, 1, 0, EV_NONE, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_pair(directed_rows[i]);
      drain_results();

      for (ph = 0; ph < 3; ph++) begin
         gap_pct       <= (ph == 0) ? 17 : (ph == 1) ? 75 : 0;
         rsp_stall_pct <= (ph == 0) ? 75 : (ph == 1) ? 17 : 0;
         for (n = 0; n < RUN_LEN; n++) send_pair(random_pair());
         drain_results();
      end

      repeat (8) @(posedge clock);
      $display("Ran %0d pairs (%0d directed), %0d results checked, %0d mismatches",
               items_taken, directed_rows.size(), results_seen, mismatch_count);
      $display("Events seen: none %0d, begin %0d, stay %0d, end %0d",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3]);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
